// File: src/rsitp_pkg.sv
// Package for the return stack and indirect target predictor.
// Holds payload and command types, branch-kind codes and default sizes.
// No dependencies; the front, back and top files reference it by scoped names.
package rsitp_pkg;

   // Default sizes (power of two for the indirect and call-size tables)
   localparam int RAS_DEPTH_DEF       = 32;
   localparam int INDIRECT_DEPTH_DEF  = 4096;
   localparam int CALL_SIZE_DEPTH_DEF = 1024;

   localparam int ADDR_W = 64;
   localparam int HIST_W = 12;
   localparam int SIZE_W = 4;

   localparam logic [SIZE_W-1:0] CALL_SIZE_RESET = 4'd4;
   localparam logic [SIZE_W-1:0] LIMIT_RESET     = 4'd10;

   // Opcodes
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   // Branch kinds; the spare code behaves as other
   localparam logic [2:0] KIND_DIRECT_JUMP   = 3'd0;
   localparam logic [2:0] KIND_INDIRECT      = 3'd1;
   localparam logic [2:0] KIND_CONDITIONAL   = 3'd2;
   localparam logic [2:0] KIND_DIRECT_CALL   = 3'd3;
   localparam logic [2:0] KIND_INDIRECT_CALL = 3'd4;
   localparam logic [2:0] KIND_RETURN        = 3'd5;
   localparam logic [2:0] KIND_OTHER         = 3'd6;
   localparam logic [2:0] KIND_SPARE         = 3'd7;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] branch_address;
      logic [2:0]        branch_kind;
      logic [ADDR_W-1:0] resolved_target;
      logic              was_taken;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] predicted_target;
      logic              predicted_always_taken;
      logic              prediction_valid;
   } rsp_type;

   // Decoded item as it travels from the front to the back
   typedef struct packed {
      logic              push;
      logic              ret_pred;
      logic              ind_pred;
      logic              ind_upd;
      logic              cond_upd;
      logic              ret_upd;
      logic              uncond;
      logic              taken;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] target;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

// File: src/rsitp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the return stack, the indirect target table and the call sizes.
// No dependencies.
module rsitp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rsitp_front.sv
// Front end: accepts request items, decodes them into commands and
// buffers them in a two-entry queue for the back end.
// Depends on rsitp_pkg.
module rsitp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rsitp_pkg::req_type      req_payload,
   input  rsitp_pkg::back_ctl_type back_ctl,
   output rsitp_pkg::q_head_type   q_head
);

   rsitp_pkg::cmd_type ent_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               accept;
   logic               is_pred;
   logic               is_indirect;
   rsitp_pkg::cmd_type dec;

   // Hold off new items while full or while the tables are being cleared
   assign req_stall = (cnt_ff == 2'd2) || back_ctl.clearing;
   assign accept    = req_valid && !req_stall;

   // Decode the item into the actions the back end carries out
   always_comb begin
      is_pred     = (req_payload.opcode == rsitp_pkg::OP_PREDICT);
      is_indirect = (req_payload.branch_kind == rsitp_pkg::KIND_INDIRECT) ||
                    (req_payload.branch_kind == rsitp_pkg::KIND_INDIRECT_CALL);
      dec.push     = is_pred &&
                     ((req_payload.branch_kind == rsitp_pkg::KIND_DIRECT_CALL) ||
                      (req_payload.branch_kind == rsitp_pkg::KIND_INDIRECT_CALL));
      dec.ret_pred = is_pred && (req_payload.branch_kind == rsitp_pkg::KIND_RETURN);
      dec.ind_pred = is_pred && is_indirect;
      dec.ind_upd  = !is_pred && is_indirect;
      dec.cond_upd = !is_pred &&
                     (req_payload.branch_kind == rsitp_pkg::KIND_CONDITIONAL);
      dec.ret_upd  = !is_pred && (req_payload.branch_kind == rsitp_pkg::KIND_RETURN);
      dec.uncond   = is_pred &&
                     (req_payload.branch_kind != rsitp_pkg::KIND_CONDITIONAL);
      dec.taken    = req_payload.was_taken;
      dec.addr     = req_payload.branch_address;
      dec.target   = req_payload.resolved_target;
   end

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (back_ctl.pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({accept, back_ctl.pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the decoded item
   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.cmd   = ent_ff[rd_ptr_ff];

endmodule

// File: src/rsitp_back.sv
// Back end: sequencer that carries out queued commands on the return
// stack, indirect target table, call-size table and taken history.
// Depends on rsitp_pkg and rsitp_ram.
module rsitp_back #(
   parameter int RAS_DEPTH       = rsitp_pkg::RAS_DEPTH_DEF,
   parameter int INDIRECT_DEPTH  = rsitp_pkg::INDIRECT_DEPTH_DEF,
   parameter int CALL_SIZE_DEPTH = rsitp_pkg::CALL_SIZE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rsitp_pkg::q_head_type         q_head,
   output rsitp_pkg::back_ctl_type       back_ctl,
   input  logic                          csr_wr_en,
   input  logic [rsitp_pkg::SIZE_W-1:0]  csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsitp_pkg::rsp_type            rsp_payload
);

   localparam int RAS_AW    = $clog2(RAS_DEPTH);
   localparam int IND_AW    = $clog2(INDIRECT_DEPTH);
   localparam int CS_AW     = $clog2(CALL_SIZE_DEPTH);
   localparam int CLR_DEPTH = (INDIRECT_DEPTH > CALL_SIZE_DEPTH) ?
                              INDIRECT_DEPTH : CALL_SIZE_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int AW        = rsitp_pkg::ADDR_W;
   localparam int SW        = rsitp_pkg::SIZE_W;
   localparam int HW        = rsitp_pkg::HIST_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RAS   = 6'b000100,
      ST_SIZE  = 6'b001000,
      ST_IND   = 6'b010000,
      ST_LEARN = 6'b100000
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [RAS_AW-1:0]      top_ff, top_in;
   logic [HW-1:0]          hist_ff, hist_in;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   logic [SW-1:0]          limit_ff, limit_in;
   logic [RAS_DEPTH-1:0]   ras_valid_ff, ras_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsitp_pkg::cmd_type     cur_ff, cur_in;
   logic [AW-1:0]          topv_ff, topv_in;
   logic [AW:0]            diff_ff, diff_in;
   logic                   rasv_ff, rasv_in;
   rsitp_pkg::rsp_type     rsp_ff, rsp_in;

   logic [RAS_AW-1:0]      top_up, top_dn;
   logic [IND_AW-1:0]      head_slot;
   logic [AW-1:0]          top_val;
   logic [AW-1:0]          ret_span;
   logic                   out_free;
   logic                   pop;

   logic                   ras_wr_en, ras_rd_en;
   logic [AW-1:0]          ras_rd_data;
   logic                   ind_wr_en, ind_rd_en;
   logic [IND_AW-1:0]      ind_wr_addr;
   logic [AW-1:0]          ind_wr_data, ind_rd_data;
   logic                   cs_wr_en, cs_rd_en;
   logic [CS_AW-1:0]       cs_wr_addr;
   logic [SW-1:0]          cs_wr_data, cs_rd_data;

   // Stack pointer wrap in both directions
   assign top_up = (top_ff == RAS_AW'(RAS_DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dn = (top_ff == '0) ? RAS_AW'(RAS_DEPTH - 1) : top_ff - 1'b1;

   // Table slot from address and history
   assign head_slot = q_head.cmd.addr[IND_AW+1:2] ^ IND_AW'(hist_ff);

   // A stack entry never pushed or already popped reads as zero
   assign top_val = rasv_ff ? ras_rd_data : '0;

   // Magnitude of the call-to-return distance
   assign ret_span = diff_ff[AW] ? (~diff_ff[AW-1:0] + 1'b1) : diff_ff[AW-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      hist_in      = hist_ff;
      clr_in       = clr_ff;
      limit_in     = limit_ff;
      ras_valid_in = ras_valid_ff;
      cur_in       = cur_ff;
      topv_in      = topv_ff;
      diff_in      = diff_ff;
      rasv_in      = rasv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ras_wr_en    = 1'b0;
      ras_rd_en    = 1'b0;
      ind_wr_en    = 1'b0;
      ind_wr_addr  = head_slot;
      ind_wr_data  = q_head.cmd.target;
      ind_rd_en    = 1'b0;
      cs_wr_en     = 1'b0;
      cs_wr_addr   = topv_ff[CS_AW-1:0];
      cs_wr_data   = ret_span[SW-1:0];
      cs_rd_en     = 1'b0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         // Sweep both tables to their reset values
         ST_CLEAR: begin
            ind_wr_en   = ((clr_ff >> IND_AW) == '0);
            ind_wr_addr = clr_ff[IND_AW-1:0];
            ind_wr_data = '0;
            cs_wr_en    = ((clr_ff >> CS_AW) == '0);
            cs_wr_addr  = clr_ff[CS_AW-1:0];
            cs_wr_data  = rsitp_pkg::CALL_SIZE_RESET;
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         // Take the next item once the output register has room
         ST_IDLE: begin
            if (q_head.valid && out_free) begin
               pop    = 1'b1;
               cur_in = q_head.cmd;
               if (q_head.cmd.push) begin
                  ras_wr_en            = 1'b1;
                  top_in               = top_up;
                  ras_valid_in[top_up] = 1'b1;
               end
               if (q_head.cmd.ret_pred || q_head.cmd.ret_upd) begin
                  ras_rd_en = 1'b1;
                  rasv_in   = ras_valid_ff[top_ff];
                  state_in  = ST_RAS;
               end else if (q_head.cmd.ind_pred) begin
                  ind_rd_en = 1'b1;
                  state_in  = ST_IND;
               end else begin
                  ind_wr_en = q_head.cmd.ind_upd;
                  if (q_head.cmd.cond_upd) begin
                     hist_in = {hist_ff[HW-2:0], q_head.cmd.taken};
                  end
                  rsp_valid_in                  = 1'b1;
                  rsp_in.predicted_target       = '0;
                  rsp_in.predicted_always_taken = q_head.cmd.uncond;
                  rsp_in.prediction_valid       = 1'b0;
               end
            end
         end

         // Stack top is in; fetch its call size or pop it
         ST_RAS: begin
            topv_in = top_val;
            if (cur_ff.ret_pred) begin
               cs_rd_en = 1'b1;
               state_in = ST_SIZE;
            end else begin
               diff_in              = {1'b0, top_val} - {1'b0, cur_ff.target};
               ras_valid_in[top_ff] = 1'b0;
               top_in               = top_dn;
               state_in             = ST_LEARN;
            end
         end

         // Return prediction: call address plus learned size
         ST_SIZE: begin
            rsp_valid_in                  = 1'b1;
            rsp_in.predicted_target       = topv_ff + AW'(cs_rd_data);
            rsp_in.predicted_always_taken = cur_ff.uncond;
            rsp_in.prediction_valid       = 1'b1;
            state_in                      = ST_IDLE;
         end

         // Indirect prediction from the target table
         ST_IND: begin
            rsp_valid_in                  = 1'b1;
            rsp_in.predicted_target       = ind_rd_data;
            rsp_in.predicted_always_taken = cur_ff.uncond;
            rsp_in.prediction_valid       = 1'b1;
            state_in                      = ST_IDLE;
         end

         // Relearn the call size when the distance is small enough
         ST_LEARN: begin
            cs_wr_en = (ret_span[AW-1:SW] == '0) && (ret_span[SW-1:0] <= limit_ff);
            rsp_valid_in                  = 1'b1;
            rsp_in.predicted_target       = '0;
            rsp_in.predicted_always_taken = 1'b0;
            rsp_in.prediction_valid       = 1'b0;
            state_in                      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         top_ff       <= '0;
         hist_ff      <= '0;
         clr_ff       <= '0;
         limit_ff     <= rsitp_pkg::LIMIT_RESET;
         ras_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         hist_ff      <= hist_in;
         clr_ff       <= clr_in;
         limit_ff     <= limit_in;
         ras_valid_ff <= ras_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      topv_ff <= topv_in;
      diff_ff <= diff_in;
      rasv_ff <= rasv_in;
      rsp_ff  <= rsp_in;
   end

   rsitp_ram #(.WIDTH(AW), .DEPTH(RAS_DEPTH)) u_ras_ram (
      .clock   (clock),
      .wr_en   (ras_wr_en),
      .wr_addr (top_up),
      .wr_data (q_head.cmd.addr),
      .rd_en   (ras_rd_en),
      .rd_addr (top_ff),
      .rd_data (ras_rd_data)
   );

   rsitp_ram #(.WIDTH(AW), .DEPTH(INDIRECT_DEPTH)) u_ind_ram (
      .clock   (clock),
      .wr_en   (ind_wr_en),
      .wr_addr (ind_wr_addr),
      .wr_data (ind_wr_data),
      .rd_en   (ind_rd_en),
      .rd_addr (head_slot),
      .rd_data (ind_rd_data)
   );

   rsitp_ram #(.WIDTH(SW), .DEPTH(CALL_SIZE_DEPTH)) u_cs_ram (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_en   (cs_rd_en),
      .rd_addr (top_val[CS_AW-1:0]),
      .rd_data (cs_rd_data)
   );

   assign back_ctl.pop      = pop;
   assign back_ctl.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;

endmodule

// File: src/return_stack_indirect_target_predictor_top.sv
// Top level of the return stack and indirect target predictor.
// Depends on rsitp_pkg, rsitp_front, rsitp_back and rsitp_ram.

// After reset the block sweeps its indirect target table to zero and its
// call-size table to four, one entry a cycle; req_stall stays high during
// that pass, while configuration writes are taken as usual. The front end
// then accepts items into a two-entry queue and the back-end sequencer
// works through them one at a time: an item that touches no table
// read (direct jumps, calls without an indirect lookup, indirect and
// conditional updates, any update other than a return) is finished in
// the idle state, an indirect predict adds one registered read of the
// target table, and a return predict or return update adds a stack read
// followed by a call-size read or the call-size relearn. The registered
// read ports of the three RAMs make these extra steps. A result waiting
// in the output register does not block accepting items into the queue.
// INDIRECT_DEPTH and CALL_SIZE_DEPTH must be powers of two; RAS_DEPTH may
// be any value from 2 upward.
module return_stack_indirect_target_predictor_top #(
   parameter int RAS_DEPTH       = rsitp_pkg::RAS_DEPTH_DEF,
   parameter int INDIRECT_DEPTH  = rsitp_pkg::INDIRECT_DEPTH_DEF,
   parameter int CALL_SIZE_DEPTH = rsitp_pkg::CALL_SIZE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rsitp_pkg::req_type            req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsitp_pkg::rsp_type            rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [rsitp_pkg::SIZE_W-1:0]  csr_wr_data
);

   rsitp_pkg::q_head_type   q_head;
   rsitp_pkg::back_ctl_type back_ctl;

   rsitp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .back_ctl    (back_ctl),
      .q_head      (q_head)
   );

   rsitp_back #(
      .RAS_DEPTH       (RAS_DEPTH),
      .INDIRECT_DEPTH  (INDIRECT_DEPTH),
      .CALL_SIZE_DEPTH (CALL_SIZE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .back_ctl    (back_ctl),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // No item enters while the tables are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_ctl.clearing |-> !(req_valid && !req_stall))
      else $error("item accepted during table clear");

   // No result leaves while the tables are being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_ctl.clearing |-> !rsp_valid)
      else $error("result shown during table clear");

   // The back end takes only a queued item
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> q_head.valid)
      else $error("pop from empty queue");

   // The back end takes an item only when its result has a place to go
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> (!rsp_valid || !rsp_stall))
      else $error("item taken while output register is held");

endmodule
